[hdl/ncps_pkg.sv]
// Shared types, constants and register codes for the nearest-color pixel search.
`timescale 1ns / 1ps

package ncps_pkg;

   localparam int MAX_WIDTH  = 1024;
   localparam int MAX_HEIGHT = 1024;

   localparam int CHAN_W   = 8;
   localparam int SQ_W     = 2 * CHAN_W;
   localparam int DIST_W   = 18;
   localparam int COL_W    = $clog2(MAX_WIDTH);
   localparam int ROW_W    = $clog2(MAX_HEIGHT);
   localparam int LW_W     = 11;
   localparam int CSR_W    = 11;
   localparam int CSR_IDX_W = 2;

   localparam int REQ_TDATA_W = 24;
   localparam int RSP_TDATA_W = 40;

   localparam logic [DIST_W-1:0] DIST_ALL_ONES = '1;
   localparam logic [DIST_W-1:0] DIST_MAX      = DIST_W'(195075);
   localparam logic [LW_W-1:0]   LW_RESET      = LW_W'(192);
   localparam logic [LW_W-1:0]   LW_MAX        = LW_W'(MAX_WIDTH);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_TARGET_C0  = 2'd0,
      CSR_TARGET_C1  = 2'd1,
      CSR_TARGET_C2  = 2'd2,
      CSR_LINE_WIDTH = 2'd3
   } csr_index_type;

   // Channel 0 sits in the lowest bits.
   typedef struct packed {
      logic [CHAN_W-1:0] c2;
      logic [CHAN_W-1:0] c1;
      logic [CHAN_W-1:0] c0;
   } pixel_type;

   typedef logic [2:0][SQ_W-1:0] sq_type;

   // Sideband that travels with a pixel through the pipeline.
   typedef struct packed {
      logic             last;
      logic [ROW_W-1:0] row;
      logic [COL_W-1:0] col;
   } pos_type;

endpackage

[hdl/nearest_color_pixel_search.sv]
// Top level of the nearest-color pixel search: finds the pixel closest to a target color.
`timescale 1ns / 1ps
// rsp_tvalid rises once the frame's last pixel has passed the input and squares registers and loaded the output.
// Throughput: one pixel transaction per cycle; the three register stages (input, squares,
// result) all advance together and only hold when a finished result has not yet been taken.
// Reset (synchronous, active high) sets the targets to zero, line width to 192, clears the
// pipeline and the output, and restarts the frame at column zero, row zero.

module nearest_color_pixel_search (
   input  logic                               clock,
   input  logic                               reset,
   // Configuration write port.
   input  logic                               csr_we,
   input  logic [ncps_pkg::CSR_IDX_W-1:0]     csr_addr,
   input  logic [ncps_pkg::CSR_W-1:0]         csr_wdata,
   // Pixel stream.
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [ncps_pkg::REQ_TDATA_W-1:0]   req_tdata,  // pixel_c0, pixel_c1, pixel_c2
   input  logic                               req_tlast,  // frame_end
   // Result stream.
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [ncps_pkg::RSP_TDATA_W-1:0]   rsp_tdata   // best_distance, best_column,
                                                          // best_row, zero padding
);
   import ncps_pkg::*;

   // Configuration registers.
   pixel_type        target_ff;
   logic [LW_W-1:0]  line_width_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff     <= '0;
         line_width_ff <= LW_RESET;
      end else if (csr_we) begin
         case (csr_index_type'(csr_addr))
            CSR_TARGET_C0:  target_ff.c0  <= csr_wdata[CHAN_W-1:0];
            CSR_TARGET_C1:  target_ff.c1  <= csr_wdata[CHAN_W-1:0];
            CSR_TARGET_C2:  target_ff.c2  <= csr_wdata[CHAN_W-1:0];
            CSR_LINE_WIDTH: line_width_ff <= csr_wdata[LW_W-1:0];
            default: ;
         endcase
      end
   end

   // The whole pipeline holds only when a frame's last pixel is ready to produce a
   // result while the previous result is still waiting in the output register.
   logic stall;
   logic advance;
   logic req_accept;

   logic      st1_valid_ff, st1_valid_in;
   pixel_type st1_pixel_ff;
   pos_type   st1_side_ff;
   logic      st2_valid_ff, st2_valid_in;
   pos_type   st2_side_ff;
   sq_type    sq_ff;

   logic      rsp_valid_ff, rsp_valid_in;
   logic      load_out;

   assign stall      = st2_valid_ff && st2_side_ff.last && rsp_valid_ff && !rsp_tready;
   assign advance    = !stall;
   assign req_tready = advance;
   assign req_accept = req_tvalid && req_tready;

   // Raster position of the incoming pixel. Column wraps at the effective line width,
   // row saturates at the last row, and both restart after a frame's last pixel.
   logic [COL_W-1:0] col_ff, col_in;
   logic [ROW_W-1:0] row_ff, row_in;
   logic [LW_W-1:0]  eff_width;
   logic [COL_W:0]   col_inc;
   logic [ROW_W:0]   row_inc;

   always_comb begin
      eff_width = line_width_ff;
      if (eff_width == '0) begin
         eff_width = LW_W'(1);
      end
      if (eff_width > LW_MAX) begin
         eff_width = LW_MAX;
      end
      col_inc = {1'b0, col_ff} + (COL_W + 1)'(1);
      row_inc = {1'b0, row_ff} + (ROW_W + 1)'(1);
      col_in  = col_ff;
      row_in  = row_ff;
      if (req_accept) begin
         if (req_tlast) begin
            col_in = '0;
            row_in = '0;
         end else if (LW_W'(col_inc) >= eff_width) begin
            col_in = '0;
            if (row_inc < (ROW_W + 1)'(MAX_HEIGHT - 1)) begin
               row_in = row_inc[ROW_W-1:0];
            end else begin
               row_in = ROW_W'(MAX_HEIGHT - 1);
            end
         end else begin
            col_in = col_inc[COL_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // Stage 1: input register.
   assign st1_valid_in = advance ? req_tvalid : st1_valid_ff;
   assign st2_valid_in = advance ? st1_valid_ff : st2_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         st1_valid_ff <= 1'b0;
         st2_valid_ff <= 1'b0;
      end else begin
         st1_valid_ff <= st1_valid_in;
         st2_valid_ff <= st2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         st1_pixel_ff     <= req_tdata[REQ_TDATA_W-1:0];
         st1_side_ff.last <= req_tlast;
         st1_side_ff.col  <= col_ff;
         st1_side_ff.row  <= row_ff;
         st2_side_ff      <= st1_side_ff;
      end
   end

   // Stage 2: squared channel differences.
   ncps_sqdist u_sqdist (
      .clock   (clock),
      .advance (advance),
      .pixel   (st1_pixel_ff),
      .target  (target_ff),
      .sq_ff   (sq_ff)
   );

   // Stage 3: sum, compare against the running minimum, and load the result on the
   // frame's last pixel. Strict less-than keeps the earliest pixel on a tie.
   logic [DIST_W-1:0] pix_dist;
   logic              better;
   logic [DIST_W-1:0] min_dist_ff, min_dist_in, pick_dist;
   logic [COL_W-1:0]  min_col_ff, min_col_in, pick_col;
   logic [ROW_W-1:0]  min_row_ff, min_row_in, pick_row;
   logic [DIST_W-1:0] out_dist_ff;
   logic [COL_W-1:0]  out_col_ff;
   logic [ROW_W-1:0]  out_row_ff;

   assign load_out = advance && st2_valid_ff && st2_side_ff.last;

   always_comb begin
      pix_dist  = DIST_W'(sq_ff[0]) + DIST_W'(sq_ff[1]) + DIST_W'(sq_ff[2]);
      better    = pix_dist < min_dist_ff;
      pick_dist = better ? pix_dist : min_dist_ff;
      pick_col  = better ? st2_side_ff.col : min_col_ff;
      pick_row  = better ? st2_side_ff.row : min_row_ff;
      min_dist_in = min_dist_ff;
      min_col_in  = min_col_ff;
      min_row_in  = min_row_ff;
      if (advance && st2_valid_ff) begin
         if (st2_side_ff.last) begin
            min_dist_in = DIST_ALL_ONES;
            min_col_in  = '0;
            min_row_in  = '0;
         end else begin
            min_dist_in = pick_dist;
            min_col_in  = pick_col;
            min_row_in  = pick_row;
         end
      end
      if (load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         min_dist_ff  <= DIST_ALL_ONES;
         min_col_ff   <= '0;
         min_row_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         min_dist_ff  <= min_dist_in;
         min_col_ff   <= min_col_in;
         min_row_ff   <= min_row_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_out) begin
         out_dist_ff <= pick_dist;
         out_col_ff  <= pick_col;
         out_row_ff  <= pick_row;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {(RSP_TDATA_W - DIST_W - COL_W - ROW_W)'(0),
                        out_row_ff, out_col_ff, out_dist_ff};

   // A frame's last pixel restarts the raster position.
   a_pos_restart: assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_tlast) |=> (col_ff == '0 && row_ff == '0))
      else $error("raster position not cleared after frame end");

   // A delivered distance never exceeds the largest possible squared distance.
   a_dist_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (out_dist_ff <= DIST_MAX))
      else $error("result distance out of range");

   // While a result is blocked, the last pixel waits in place.
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      stall |=> (st2_valid_ff && $stable(st2_side_ff)))
      else $error("pipeline moved while stalled");

   // Emitting a result resets the running minimum for the next frame.
   a_min_clear: assert property (@(posedge clock) disable iff (reset)
      load_out |=> (min_dist_ff == DIST_ALL_ONES))
      else $error("running minimum not cleared after result");

   // A taken result with nothing new behind it leaves the output empty.
   a_out_drain: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_tready && !load_out) |=> !rsp_valid_ff)
      else $error("result repeated");

endmodule

[hdl/ncps_sqdist.sv]
// Per-channel absolute difference and square, registered once.
`timescale 1ns / 1ps

module ncps_sqdist (
   input  logic              clock,
   input  logic              advance,
   input  ncps_pkg::pixel_type pixel,
   input  ncps_pkg::pixel_type target,
   output ncps_pkg::sq_type  sq_ff
);
   import ncps_pkg::*;

   logic [2:0][CHAN_W-1:0] pix_ch;
   logic [2:0][CHAN_W-1:0] tgt_ch;
   logic [2:0][CHAN_W-1:0] diff;
   sq_type                 sq_in;

   assign pix_ch = {pixel.c2, pixel.c1, pixel.c0};
   assign tgt_ch = {target.c2, target.c1, target.c0};

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         diff[i]  = (pix_ch[i] >= tgt_ch[i]) ? (pix_ch[i] - tgt_ch[i])
                                             : (tgt_ch[i] - pix_ch[i]);
         sq_in[i] = SQ_W'(diff[i]) * SQ_W'(diff[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         sq_ff <= sq_in;
      end
   end

endmodule

[sim/ncps_checker.sv]
// Checker for the nearest-color pixel search: predicts each frame's best pixel and compares.
`timescale 1ns / 1ps

module ncps_checker (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_we,
   input  logic [ncps_pkg::CSR_IDX_W-1:0]   csr_addr,
   input  logic [ncps_pkg::CSR_W-1:0]       csr_wdata,
   input  logic                             req_tvalid,
   input  logic                             req_tready,
   input  logic [ncps_pkg::REQ_TDATA_W-1:0] req_tdata,   // pixel_c0, pixel_c1, pixel_c2
   input  logic                             req_tlast,   // frame_end
   input  logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   input  logic [ncps_pkg::RSP_TDATA_W-1:0] rsp_tdata,   // best_distance, best_column,
                                                         // best_row, padding
   output int                               mismatch_count,
   output int                               results_pending
);
   import ncps_pkg::*;

   // Field order follows rsp_tdata from the top bit down.
   typedef struct packed {
      logic [ROW_W-1:0]  row;
      logic [COL_W-1:0]  col;
      logic [DIST_W-1:0] distance;
   } frame_best_type;

   localparam int BEST_W = $bits(frame_best_type);

   pixel_type      target_color;
   logic [LW_W-1:0] line_width;
   int             scan_col;
   int             scan_row;
   frame_best_type running_best;
   frame_best_type frame_best_q[$];
   int             errors = 0;

   function automatic logic [DIST_W-1:0] color_distance(pixel_type px, pixel_type goal);
      int d0 = int'(px.c0) - int'(goal.c0);
      int d1 = int'(px.c1) - int'(goal.c1);
      int d2 = int'(px.c2) - int'(goal.c2);
      return DIST_W'(d0 * d0 + d1 * d1 + d2 * d2);
   endfunction

   function automatic int effective_width(logic [LW_W-1:0] lw);
      if (lw == '0) return 1;
      if (lw > LW_MAX) return MAX_WIDTH;
      return int'(lw);
   endfunction

   task automatic clear_frame();
      scan_col              = 0;
      scan_row              = 0;
      running_best.distance = DIST_ALL_ONES;
      running_best.col      = '0;
      running_best.row      = '0;
   endtask

   always @(posedge clock) begin : predict_and_compare
      pixel_type         px;
      logic [DIST_W-1:0] px_dist;
      frame_best_type    got;
      frame_best_type    want;
      if (reset) begin
         target_color = '0;
         line_width   = LW_RESET;
         clear_frame();
         frame_best_q.delete();
      end else begin
         // A result leaves only after its frame's last pixel has passed the block's registers, so it is
         // matched before this edge's pixel can add a new expectation.
         if (rsp_tvalid && rsp_tready) begin
            got = frame_best_type'(rsp_tdata[BEST_W-1:0]);
            if (frame_best_q.size() == 0) begin
               $display("%0t: unexpected result, expected none, got distance %0d column %0d row %0d",
                        $time, got.distance, got.col, got.row);
               errors++;
            end else begin
               want = frame_best_q.pop_front();
               if (got.distance !== want.distance) begin
                  $display("%0t: best_distance expected %0d, got %0d",
                           $time, want.distance, got.distance);
                  errors++;
               end
               if (got.col !== want.col) begin
                  $display("%0t: best_column expected %0d, got %0d", $time, want.col, got.col);
                  errors++;
               end
               if (got.row !== want.row) begin
                  $display("%0t: best_row expected %0d, got %0d", $time, want.row, got.row);
                  errors++;
               end
            end
         end
         if (csr_we) begin
            case (csr_index_type'(csr_addr))
               CSR_TARGET_C0:  target_color.c0 = csr_wdata[CHAN_W-1:0];
               CSR_TARGET_C1:  target_color.c1 = csr_wdata[CHAN_W-1:0];
               CSR_TARGET_C2:  target_color.c2 = csr_wdata[CHAN_W-1:0];
               CSR_LINE_WIDTH: line_width      = csr_wdata[LW_W-1:0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) begin
            px      = pixel_type'(req_tdata);
            px_dist = color_distance(px, target_color);
            // Strict less-than keeps the earliest pixel on ties.
            if (px_dist < running_best.distance) begin
               running_best.distance = px_dist;
               running_best.col      = COL_W'(scan_col);
               running_best.row      = ROW_W'(scan_row);
            end
            if (req_tlast) begin
               frame_best_q.push_back(running_best);
               clear_frame();
            end else if (scan_col + 1 >= effective_width(line_width)) begin
               scan_col = 0;
               if (scan_row + 1 < MAX_HEIGHT) scan_row++;
            end else begin
               scan_col++;
            end
         end
      end
      mismatch_count  <= errors;
      results_pending <= frame_best_q.size();
   end

endmodule

[sim/nearest_color_pixel_search_tb.sv]
// Testbench top for the nearest-color pixel search: drives pixel frames and gives the verdict.
`timescale 1ns / 1ps

module nearest_color_pixel_search_tb;
   import ncps_pkg::*;

   localparam int RANDOM_ITEMS = 1500;
   localparam int HOLD_CYCLES  = 400;

   typedef enum int {SHADE_RANDOM, SHADE_NEAR, SHADE_EXACT, SHADE_FAR} shade_type;

   // All block inputs start at known values; reset is high from time zero.
   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   csr_we     = 1'b0;
   logic [CSR_IDX_W-1:0]   csr_addr   = '0;
   logic [CSR_W-1:0]       csr_wdata  = '0;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata  = '0;   // pixel_c0, pixel_c1, pixel_c2
   logic                   req_tlast  = 1'b0; // frame_end
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;         // best_distance, best_column, best_row, padding

   int mismatch_count;
   int results_pending;

   // Stimulus controls shared with the result-side process.
   bit quiet     = 1'b0;   // when set, neither side idles
   bit hold_req  = 1'b0;   // asks the receiver for one long hold-off
   bit hold_done = 1'b0;
   int hold_left = 0;

   // The stimulus keeps its own copy of the target so it can aim pixels at it.
   pixel_type goal = '0;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   nearest_color_pixel_search dut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   ncps_checker best_match_check (
      .clock           (clock),
      .reset           (reset),
      .csr_we          (csr_we),
      .csr_addr        (csr_addr),
      .csr_wdata       (csr_wdata),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_tdata       (req_tdata),
      .req_tlast       (req_tlast),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tdata       (rsp_tdata),
      .mismatch_count  (mismatch_count),
      .results_pending (results_pending)
   );

   // Result side. It normally drops ready at random, with a chance of 7 in 100. Once the
   // stimulus asks for it, ready stays low for a long counted stretch so the
   // pipeline fills behind the untaken result and the block stalls its input.
   always @(negedge clock) begin
      if (hold_left > 0) begin
         rsp_tready <= 1'b0;
         hold_left  <= hold_left - 1;
      end else if (hold_req && !hold_done) begin
         rsp_tready <= 1'b0;
         hold_left  <= HOLD_CYCLES;
         hold_done  <= 1'b1;
      end else begin
         rsp_tready <= quiet || ($urandom_range(99) >= 7);
      end
   end

   function automatic logic [CHAN_W-1:0] nudge(logic [CHAN_W-1:0] c);
      int v = int'(c) + $urandom_range(0, 8) - 4;
      if (v < 0) v = 0;
      if (v > 255) v = 255;
      return CHAN_W'(v);
   endfunction

   // Produces a pixel relative to the current target color.
   function automatic pixel_type shade(shade_type kind);
      pixel_type px;
      case (kind)
         SHADE_NEAR: begin
            px.c0 = nudge(goal.c0);
            px.c1 = nudge(goal.c1);
            px.c2 = nudge(goal.c2);
         end
         SHADE_EXACT: px = goal;
         SHADE_FAR:   px = goal ^ 24'h808080;
         default:     px = pixel_type'($urandom);
      endcase
      return px;
   endfunction

   // Offers one pixel, optionally after a short random gap, and returns at the
   // falling edge after the transaction. tvalid is left high for the next one.
   task automatic send_pixel(pixel_type px, logic last);
      if (!quiet && $urandom_range(99) < 7) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= px;
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   // Stops offering pixels, waits for every outstanding result, then lets the
   // pipeline run out so no pixel is still inside the block.
   task automatic settle();
      req_tvalid <= 1'b0;
      do @(negedge clock); while (results_pending != 0);
      repeat (4) @(negedge clock);
   endtask

   // Register writes happen only with the block drained.
   task automatic write_reg(csr_index_type idx, int value);
      settle();
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= CSR_W'(value);
      case (idx)
         CSR_TARGET_C0: goal.c0 = CHAN_W'(value);
         CSR_TARGET_C1: goal.c1 = CHAN_W'(value);
         CSR_TARGET_C2: goal.c2 = CHAN_W'(value);
         default: ;
      endcase
      @(negedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
   endtask

   // A run of pixels far from the target with one exact hit at hit_at.
   task automatic send_frame(int len, int hit_at, bit close);
      for (int i = 0; i < len; i++)
         send_pixel(shade(i == hit_at ? SHADE_EXACT : SHADE_FAR), close && (i == len - 1));
   endtask

   // Picks a line width, leaning on the edges: zero, one, the maximum, beyond it.
   function automatic int pick_width();
      case ($urandom_range(7))
         0:       return 0;
         1:       return 1;
         2:       return MAX_WIDTH;
         3:       return 2047;
         4:       return $urandom_range(MAX_WIDTH + 1, 2047);
         default: return $urandom_range(2, 24);
      endcase
   endfunction

   function automatic int pick_target();
      if ($urandom_range(3) == 0) return $urandom_range(1) ? 255 : 0;
      return $urandom_range(0, 255);
   endfunction

   initial begin : stimulus
      int        sent;
      int        phase;
      int        frames;
      int        len;
      int        roll;
      bit        close;
      bit        frame_open;
      pixel_type px;
      pixel_type prev;

      sent       = 0;
      phase      = 0;
      frame_open = 1'b0;
      prev       = '0;

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed part. With the reset target of black, pure white gives the
      // largest distance and pure black gives zero.
      send_pixel(pixel_type'(24'hFFFFFF), 1'b1);
      send_pixel(pixel_type'(24'h000000), 1'b1);

      // Target at the top of every channel, pixel at the bottom.
      write_reg(CSR_TARGET_C0, 255);
      write_reg(CSR_TARGET_C1, 255);
      write_reg(CSR_TARGET_C2, 255);
      send_pixel(pixel_type'(24'h000000), 1'b1);

      // Mid-range target; two exact hits in one frame, the earlier must win.
      write_reg(CSR_TARGET_C0, 18);
      write_reg(CSR_TARGET_C1, 200);
      write_reg(CSR_TARGET_C2, 97);
      send_pixel(shade(SHADE_FAR), 1'b0);
      send_pixel(shade(SHADE_EXACT), 1'b0);
      send_pixel(shade(SHADE_NEAR), 1'b0);
      send_pixel(shade(SHADE_EXACT), 1'b1);

      // A width of zero behaves as one pixel per row: every pixel opens a row.
      write_reg(CSR_LINE_WIDTH, 0);
      send_frame(3, 2, 1'b1);
      // Width one, with the hit on the first pixel of the frame.
      write_reg(CSR_LINE_WIDTH, 1);
      send_frame(3, 0, 1'b1);
      // Width two: the hit lands on column one of row one.
      write_reg(CSR_LINE_WIDTH, 2);
      send_frame(5, 3, 1'b1);

      // Width lowered in the middle of a row: the column already past the new
      // width is still reported, then the row advances.
      write_reg(CSR_LINE_WIDTH, 10);
      send_frame(8, -1, 1'b0);
      write_reg(CSR_LINE_WIDTH, 3);
      send_frame(4, 0, 1'b1);

      // Longer frames reach the edges of the column and row counters: the last
      // column at the largest width, a width above the maximum that must be
      // clamped (the hit then opens row one), and the row saturating.
      write_reg(CSR_LINE_WIDTH, MAX_WIDTH);
      send_frame(MAX_WIDTH, MAX_WIDTH - 1, 1'b1);
      write_reg(CSR_LINE_WIDTH, 2047);
      send_frame(MAX_WIDTH + 2, MAX_WIDTH, 1'b1);
      write_reg(CSR_LINE_WIDTH, 1);
      send_frame(MAX_HEIGHT + 6, MAX_HEIGHT + 3, 1'b1);
      write_reg(CSR_LINE_WIDTH, 192);

      // Random part, in phases. Each phase may retarget and resize between
      // frames or even mid-frame, then sends a few frames of mixed pixels:
      // random colors, colors near or on the target, and repeats that make ties.
      while (sent < RANDOM_ITEMS) begin
         quiet    <= (phase >= 10) && (phase < 16);
         if (frame_open || $urandom_range(2) == 0) begin
            if ($urandom_range(1)) write_reg(CSR_TARGET_C0, pick_target());
            if ($urandom_range(1)) write_reg(CSR_TARGET_C1, pick_target());
            if ($urandom_range(1)) write_reg(CSR_TARGET_C2, pick_target());
            if ($urandom_range(1)) write_reg(CSR_LINE_WIDTH, pick_width());
         end
         // The hold-off starts only after any register writes have drained the
         // block, so it overlaps the frames below.
         hold_req <= hold_req || (phase == 6);
         // During the receiver hold-off, many short frames keep the input busy.
         frames = (phase == 6) ? 8 : $urandom_range(1, 4);
         for (int f = 0; f < frames; f++) begin
            if (phase == 6)
               len = $urandom_range(1, 3);
            else if ($urandom_range(9) == 0)
               len = $urandom_range(30, 120);
            else
               len = $urandom_range(1, 16);
            close = !((f == frames - 1) && ($urandom_range(4) == 0));
            for (int i = 0; i < len; i++) begin
               roll = $urandom_range(9);
               if (roll <= 3)      px = shade(SHADE_RANDOM);
               else if (roll <= 5) px = shade(SHADE_NEAR);
               else if (roll == 6) px = shade(SHADE_EXACT);
               else if (roll == 7) px = shade(SHADE_FAR);
               else                px = prev;
               send_pixel(px, close && (i == len - 1));
               prev = px;
               sent++;
            end
            frame_open = !close;
         end
         phase++;
      end
      if (frame_open) send_pixel(shade(SHADE_RANDOM), 1'b1);

      settle();
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   // Run limit, far above the slowest legal run.
   initial begin
      #1000000;
      $display("Mismatches found");
      $finish;
   end

endmodule

[sim.f]
hdl/ncps_pkg.sv
hdl/ncps_sqdist.sv
hdl/nearest_color_pixel_search.sv
sim/ncps_checker.sv
sim/nearest_color_pixel_search_tb.sv
